// ----- rtl/core/mcfr_pkg.sv -----
// Shared types and constants for the motor command frame receiver.
package mcfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SLOPE_W  = 16;
    localparam int unsigned SPEED_W  = 14;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h54;
    localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'hff;
    localparam logic [BYTE_W-1:0] SCALE_RESET   = 8'd64;

    // Frame layout.
    localparam logic [POS_W-1:0] POS_HEADER  = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST   = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST    = 3'd4;
    localparam logic [POS_W-1:0] POS_TRAILER = 3'd5;

    localparam int unsigned IDX_ADDR    = 0;
    localparam int unsigned IDX_CMD     = 1;
    localparam int unsigned IDX_SLOPE_H = 2;
    localparam int unsigned IDX_SLOPE_L = 3;
    localparam int unsigned NUM_BYTES   = 4;

    localparam int unsigned DIR_BIT = 7;
    localparam logic [BYTE_W-1:0] SPEED_MASK = 8'h3f;

    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_RUN   = 2'd1,
        ST_STOP  = 2'd2,
        ST_ERROR = 2'd3
    } t_sys_state;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_STOP = 2'd2
    } t_state_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic [1:0]        system_state;
    } t_in_item;

    // Deframer status handed to the command decoder.
    typedef struct packed {
        logic               done;
        logic               bad;
        logic [BYTE_W-1:0]  addr;
        logic [BYTE_W-1:0]  cmd;
        logic [SLOPE_W-1:0] slope;
    } t_frame_info;

    typedef struct packed {
        logic               frame_done;
        logic               frame_bad;
        logic [BYTE_W-1:0]  device_address;
        logic [SLOPE_W-1:0] slope_angle;
        logic [SPEED_W-1:0] target_speed;
        t_state_cmd         state_command;
        logic               direction_ccw;
        logic               send_reply;
        logic               restart_request;
    } t_result;

endpackage

// ----- rtl/core/mcfr_in_if.sv -----
// Request channel carrying one received byte and the current system state.
interface mcfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic [1:0] system_state;

    modport source (output valid, output rx_byte, output system_state, input ready);
    modport sink (input valid, input rx_byte, input system_state, output ready);
endinterface

// ----- rtl/core/mcfr_out_if.sv -----
// Request channel carrying one decoded result per received byte.
interface mcfr_out_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic        frame_bad;
    logic [7:0]  device_address;
    logic [15:0] slope_angle;
    logic [13:0] target_speed;
    logic [1:0]  state_command;
    logic        direction_ccw;
    logic        send_reply;
    logic        restart_request;

    modport source (
        output valid, output frame_done, output frame_bad, output device_address,
        output slope_angle, output target_speed, output state_command,
        output direction_ccw, output send_reply, output restart_request,
        input ready
    );
    modport sink (
        input valid, input frame_done, input frame_bad, input device_address,
        input slope_angle, input target_speed, input state_command,
        input direction_ccw, input send_reply, input restart_request,
        output ready
    );
endinterface

// ----- rtl/core/motor_command_frame_receiver.sv -----
// Top level of the motor command frame receiver.
//
// Usage:
//   i_in carries one received serial byte per request together with the
//   current system state (wait, run, stop, error). o_out carries exactly one
//   result per accepted byte: frame status, address, slope angle, target
//   speed, state command, latched direction, reply and restart requests.
//   The configuration port writes the header, trailer and speed scale
//   registers; write only while no request is in flight.
// Timing:
//   A byte is captured in an input register, decoded by one level of compare
//   and an 8 by 6 bit multiply, and then moves on into the output register;
//   one byte can be taken in every cycle while o_out.ready stays high.
// Reset:
//   Synchronous, active low. The block starts hunting for a header, the
//   direction is clockwise and the configuration registers take their defaults.
// Stalls:
//   When the receiver holds o_out.ready low, the output register keeps its
//   result and the input register still takes one more byte; after that
//   i_in.ready drops until the result is taken.
module motor_command_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mcfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mcfr_pkg::BYTE_W-1:0]    i_cfg_data,
    mcfr_in_if.sink                        i_in,
    mcfr_out_if.source                     o_out
);

    logic [mcfr_pkg::BYTE_W-1:0] r_header;
    logic [mcfr_pkg::BYTE_W-1:0] r_trailer;
    logic [mcfr_pkg::BYTE_W-1:0] r_scale;

    logic                  r_s1_valid;
    mcfr_pkg::t_in_item    r_s1;
    logic                  r_out_valid;
    mcfr_pkg::t_result     r_out;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    mcfr_pkg::t_frame_info frame;
    mcfr_pkg::t_result     result;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= mcfr_pkg::HEADER_RESET;
            r_trailer <= mcfr_pkg::TRAILER_RESET;
            r_scale   <= mcfr_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcfr_pkg::CFG_HEADER:  r_header  <= i_cfg_data;
                mcfr_pkg::CFG_TRAILER: r_trailer <= i_cfg_data;
                mcfr_pkg::CFG_SCALE:   r_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.rx_byte      <= i_in.rx_byte;
            r_s1.system_state <= i_in.system_state;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    mcfr_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_s1.rx_byte),
        .i_header  (r_header),
        .i_trailer (r_trailer),
        .o_frame   (frame)
    );

    mcfr_command u_command (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_frame        (frame),
        .i_system_state (r_s1.system_state),
        .i_scale        (r_scale),
        .o_result       (result)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.frame_done      = r_out.frame_done;
    assign o_out.frame_bad       = r_out.frame_bad;
    assign o_out.device_address  = r_out.device_address;
    assign o_out.slope_angle     = r_out.slope_angle;
    assign o_out.target_speed    = r_out.target_speed;
    assign o_out.state_command   = r_out.state_command;
    assign o_out.direction_ccw   = r_out.direction_ccw;
    assign o_out.send_reply      = r_out.send_reply;
    assign o_out.restart_request = r_out.restart_request;

`ifndef SYNTH
    // A result is never both a completed frame and a dropped one.
    a_done_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_done && r_out.frame_bad))
        else $error("frame_done and frame_bad both set");

    // Any state command or request comes only with a completed frame.
    a_cmd_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.state_command != mcfr_pkg::CMD_NONE ||
            r_out.send_reply || r_out.restart_request)) |-> r_out.frame_done)
        else $error("command issued without a completed frame");

    // A restart request always goes out with a status reply.
    a_restart_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restart_request) |-> r_out.send_reply)
        else $error("restart request without reply");

    // A stalled result stays in the output register while the input stage is full.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_s1_valid) |=> (r_out_valid && r_s1_valid))
        else $error("pipeline lost a request during a stall");
`endif

endmodule

// ----- rtl/core/mcfr_deframer.sv -----
// Frame position tracker and frame byte store.
module mcfr_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [mcfr_pkg::BYTE_W-1:0]  i_byte,
    input  logic [mcfr_pkg::BYTE_W-1:0]  i_header,
    input  logic [mcfr_pkg::BYTE_W-1:0]  i_trailer,
    output mcfr_pkg::t_frame_info        o_frame
);

    logic [mcfr_pkg::POS_W-1:0]  r_pos;
    logic [mcfr_pkg::POS_W-1:0]  n_pos;
    logic [mcfr_pkg::BYTE_W-1:0] r_bytes [mcfr_pkg::NUM_BYTES];
    logic                        store_en;
    logic [mcfr_pkg::POS_W-1:0]  pos_off;
    logic [1:0]                  store_idx;

    assign pos_off   = r_pos - mcfr_pkg::POS_FIRST;
    assign store_idx = pos_off[1:0];

    always_comb begin
        n_pos         = mcfr_pkg::POS_HEADER;
        store_en      = 1'b0;
        o_frame.done  = 1'b0;
        o_frame.bad   = 1'b0;
        o_frame.addr  = r_bytes[mcfr_pkg::IDX_ADDR];
        o_frame.cmd   = r_bytes[mcfr_pkg::IDX_CMD];
        o_frame.slope = {r_bytes[mcfr_pkg::IDX_SLOPE_H], r_bytes[mcfr_pkg::IDX_SLOPE_L]};
        case (r_pos) inside
            [mcfr_pkg::POS_FIRST:mcfr_pkg::POS_LAST]: begin
                store_en = 1'b1;
                n_pos    = r_pos + 3'd1;
            end
            mcfr_pkg::POS_TRAILER: begin
                n_pos        = mcfr_pkg::POS_HEADER;
                o_frame.done = (i_byte == i_trailer);
                o_frame.bad  = (i_byte != i_trailer);
            end
            default: begin
                // Anything but the header byte is dropped while hunting.
                n_pos = (i_byte == i_header) ? mcfr_pkg::POS_FIRST : mcfr_pkg::POS_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= mcfr_pkg::POS_HEADER;
        end else if (i_advance) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && store_en) begin
            r_bytes[store_idx] <= i_byte;
        end
    end

endmodule

// ----- rtl/core/mcfr_command.sv -----
// Command decoder: speed, state command, reply and restart, and the latched direction.
module mcfr_command (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  mcfr_pkg::t_frame_info        i_frame,
    input  logic [1:0]                   i_system_state,
    input  logic [mcfr_pkg::BYTE_W-1:0]  i_scale,
    output mcfr_pkg::t_result            o_result
);

    logic                        r_dir;
    logic                        n_dir;
    logic                        cmd_dir;
    logic                        cmd_zero;
    logic [mcfr_pkg::BYTE_W-1:0] speed_code;
    logic [15:0]                 speed_full;
    mcfr_pkg::t_sys_state        sys_state;

    assign sys_state  = mcfr_pkg::t_sys_state'(i_system_state);
    assign cmd_dir    = i_frame.cmd[mcfr_pkg::DIR_BIT];
    assign cmd_zero   = (i_frame.cmd == '0);
    assign speed_code = i_frame.cmd & mcfr_pkg::SPEED_MASK;
    assign speed_full = i_scale * speed_code;

    always_comb begin
        o_result                 = '0;
        o_result.state_command   = mcfr_pkg::CMD_NONE;
        n_dir                    = r_dir;
        o_result.frame_bad       = i_frame.bad;
        if (i_frame.done) begin
            o_result.frame_done     = 1'b1;
            o_result.device_address = i_frame.addr;
            o_result.slope_angle    = i_frame.slope;
            o_result.target_speed   = speed_full[mcfr_pkg::SPEED_W-1:0];
            case (sys_state)
                mcfr_pkg::ST_WAIT: begin
                    if (!cmd_zero) begin
                        o_result.state_command = mcfr_pkg::CMD_RUN;
                        n_dir                  = cmd_dir;
                    end else begin
                        o_result.send_reply = 1'b1;
                    end
                end
                mcfr_pkg::ST_RUN: begin
                    // A direction reversal stops the motor without a reply; a zero
                    // command stops it and replies only if its direction bit matches.
                    if (cmd_zero) begin
                        o_result.state_command = mcfr_pkg::CMD_STOP;
                    end
                    if (cmd_dir != r_dir) begin
                        o_result.state_command = mcfr_pkg::CMD_STOP;
                    end else begin
                        o_result.send_reply = 1'b1;
                    end
                end
                mcfr_pkg::ST_ERROR: begin
                    o_result.restart_request = cmd_zero;
                    o_result.send_reply      = 1'b1;
                end
                default: begin
                    o_result.send_reply = 1'b1;
                end
            endcase
        end
        o_result.direction_ccw = n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
        end else if (i_advance) begin
            r_dir <= n_dir;
        end
    end

endmodule
